// ===== rtl/core/sector_remap_read_splitter_core_macros.svh =====
// assertion macros shared by the read splitter rtl
`ifndef SECTOR_REMAP_READ_SPLITTER_CORE_MACROS_SVH
`define SECTOR_REMAP_READ_SPLITTER_CORE_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define SRRS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SRRS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/srrs_pkg.sv =====
// types, constants and codes shared by the read splitter modules
`default_nettype none

package srrs_pkg;

    localparam int POS_W     = 40;
    localparam int LEN_W     = 32;
    localparam int SS_W      = 28;
    localparam int IMG_W     = 41;
    localparam int BASE_W    = 40;
    localparam int OFF_W     = 45;
    localparam int IDX_W     = 16;
    localparam int VAL_W     = 16;
    localparam int CFG_W     = 41;
    localparam int CFG_IDX_W = 2;
    localparam int BW_W      = 41;
    localparam int PROD_W    = 44;

    localparam int DEF_TABLE_DEPTH  = 65536;
    localparam int DEF_MAX_SEGMENTS = 64;

    localparam int JOB_DEPTH  = 4;
    localparam int JOB_PTR_W  = 2;
    localparam int JOB_CNT_W  = 3;

    localparam int DIV_CNT_W = 6;

    localparam logic [SS_W-1:0] MIN_SECTOR = 28'd256;
    localparam logic [SS_W-1:0] RST_SECTOR = 28'd32768;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_CUT    = 2'd1;
    localparam logic [1:0] STATUS_BEYOND = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 2'd0,
        CFG_SEC_BYTES = 2'd1,
        CFG_IMAGE_SIZE = 2'd2,
        CFG_BASE      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  entry_index;
        logic [VAL_W-1:0]  entry_value;
        logic [POS_W-1:0]  read_offset;
        logic [LEN_W-1:0]  read_length;
    } t_in_item;

    typedef struct packed {
        logic [OFF_W-1:0]  seg_offset;
        logic [LEN_W-1:0]  seg_length;
        logic              last;
        logic [1:0]        status;
    } t_out_item;

    typedef struct packed {
        logic              mode;
        logic [SS_W-1:0]   sec_bytes;
        logic [IMG_W-1:0]  image_size;
        logic [BASE_W-1:0] base;
    } t_cfg;

    typedef enum logic [1:0] {
        JOB_LOAD,
        JOB_EMPTY,
        JOB_PASS,
        JOB_SPLIT
    } t_job_kind;

    typedef struct packed {
        t_job_kind         kind;
        logic [IDX_W-1:0]  index;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  pos;
        logic [LEN_W-1:0]  len;
    } t_job;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_CHECK,
        BK_MUL,
        BK_EMIT,
        BK_BEYOND
    } t_back_state;

endpackage

`default_nettype wire

// ===== rtl/core/srrs_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module srrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srrs_front.sv =====
// front end: takes items, clips reads to the image and classifies them into jobs
`default_nettype none

module srrs_front #(
    parameter int TABLE_DEPTH = srrs_pkg::DEF_TABLE_DEPTH
) (
    input  wire srrs_pkg::t_in_item i_item,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire srrs_pkg::t_cfg     i_cfg,
    input  wire logic               i_job_full,
    output logic                    o_job_push,
    output srrs_pkg::t_job          o_job
);

    logic [srrs_pkg::IMG_W-1:0] pos_ext;
    logic [srrs_pkg::IMG_W-1:0] avail;
    logic                       past_end;
    logic [srrs_pkg::LEN_W-1:0] clip_len;
    logic                       load_ok;

    always_comb begin
        pos_ext  = {1'b0, i_item.read_offset};
        past_end = pos_ext >= i_cfg.image_size;
        avail    = i_cfg.image_size - pos_ext;
        if (avail < srrs_pkg::IMG_W'(i_item.read_length)) begin
            clip_len = avail[srrs_pkg::LEN_W-1:0];
        end else begin
            clip_len = i_item.read_length;
        end
        // loads beyond the table are dropped here and never queued
        load_ok = 32'(i_item.entry_index) < 32'(TABLE_DEPTH);
    end

    always_comb begin
        o_job.index = i_item.entry_index;
        o_job.value = i_item.entry_value;
        o_job.pos   = i_item.read_offset;
        o_job.len   = clip_len;
        priority if (i_item.cmd == srrs_pkg::CMD_LOAD) begin
            o_job.kind = srrs_pkg::JOB_LOAD;
        end else if (past_end || (clip_len == '0)) begin
            o_job.kind = srrs_pkg::JOB_EMPTY;
        end else if (!i_cfg.mode) begin
            o_job.kind = srrs_pkg::JOB_PASS;
        end else begin
            o_job.kind = srrs_pkg::JOB_SPLIT;
        end
    end

    assign o_full     = i_job_full;
    assign o_job_push = i_push && !i_job_full
                        && ((i_item.cmd == srrs_pkg::CMD_READ) || load_ok);

endmodule

`default_nettype wire

// ===== rtl/core/srrs_job_fifo.sv =====
// short job queue between the front end and the back end
`default_nettype none

module srrs_job_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire srrs_pkg::t_job  i_job,
    output logic                 o_full,
    input  wire logic            i_pop,
    output srrs_pkg::t_job       o_head,
    output logic                 o_empty
);

    srrs_pkg::t_job                  r_mem [srrs_pkg::JOB_DEPTH];
    logic [srrs_pkg::JOB_PTR_W-1:0]  r_wptr;
    logic [srrs_pkg::JOB_PTR_W-1:0]  r_rptr;
    logic [srrs_pkg::JOB_CNT_W-1:0]  r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = r_count == srrs_pkg::JOB_CNT_W'(srrs_pkg::JOB_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srrs_back.sv =====
// back end: remap table, serial divider and segment generator with output register
`default_nettype none

module srrs_back #(
    parameter int TABLE_DEPTH  = srrs_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_SEGMENTS = srrs_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire srrs_pkg::t_cfg      i_cfg,
    input  wire logic                i_job_empty,
    input  wire srrs_pkg::t_job      i_job,
    output logic                     o_job_pop,
    output srrs_pkg::t_out_item      o_seg,
    output logic                     o_empty,
    input  wire logic                i_pop
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [CW-1:0] CNT_LAST = CW'(MAX_SEGMENTS - 1);
    localparam logic [srrs_pkg::DIV_CNT_W-1:0] DIV_LAST =
        srrs_pkg::DIV_CNT_W'(srrs_pkg::POS_W - 1);
    localparam logic [srrs_pkg::POS_W-1:0] SEC_LIMIT = srrs_pkg::POS_W'(TABLE_DEPTH);

    srrs_pkg::t_back_state           r_state;
    srrs_pkg::t_back_state           n_state;
    logic [srrs_pkg::POS_W-1:0]      r_qd;
    logic [srrs_pkg::SS_W-1:0]       r_rem;
    logic [srrs_pkg::SS_W-1:0]       r_ss;
    logic [srrs_pkg::DIV_CNT_W-1:0]  r_div_cnt;
    logic [srrs_pkg::LEN_W-1:0]      r_remaining;
    logic [CW-1:0]                   r_cnt;
    logic [srrs_pkg::LEN_W-1:0]      r_len;
    logic [srrs_pkg::LEN_W-1:0]      r_rem_next;
    logic [srrs_pkg::BW_W-1:0]       r_base_within;
    logic [srrs_pkg::PROD_W-1:0]     r_prod;
    srrs_pkg::t_out_item             r_out;
    logic                            r_out_valid;

    logic                            out_free;
    logic                            head_valid;
    logic                            head_single;
    logic                            beyond;
    logic [srrs_pkg::SS_W:0]         rem_sh;
    logic                            div_ge;
    logic [srrs_pkg::SS_W-1:0]       rem_new;
    logic [srrs_pkg::SS_W-1:0]       room;
    logic [srrs_pkg::LEN_W-1:0]      seg_len;
    logic                            seg_done;
    logic                            at_limit;
    logic                            seg_last;
    logic [srrs_pkg::SS_W-1:0]       ss_eff;

    logic                            ram_we;
    logic                            ram_re;
    logic [AW-1:0]                   ram_waddr;
    logic [AW-1:0]                   ram_raddr;
    logic [srrs_pkg::VAL_W-1:0]      ram_rdata;

    logic                            out_load;
    srrs_pkg::t_out_item             out_data;

    srrs_ram #(
        .WIDTH (srrs_pkg::VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_job.value),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        out_free    = !r_out_valid || i_pop;
        head_valid  = !i_job_empty;
        head_single = (i_job.kind == srrs_pkg::JOB_EMPTY) || (i_job.kind == srrs_pkg::JOB_PASS);
        ss_eff      = (i_cfg.sec_bytes < srrs_pkg::MIN_SECTOR) ? srrs_pkg::MIN_SECTOR
                                                               : i_cfg.sec_bytes;
        // restoring division step, quotient bits shift in behind the dividend
        rem_sh  = {r_rem, r_qd[srrs_pkg::POS_W-1]};
        div_ge  = rem_sh >= {1'b0, r_ss};
        rem_new = div_ge ? srrs_pkg::SS_W'(rem_sh - {1'b0, r_ss})
                         : rem_sh[srrs_pkg::SS_W-1:0];
        beyond  = r_qd >= SEC_LIMIT;
        room    = r_ss - r_rem;
        seg_len = (srrs_pkg::LEN_W'(room) < r_remaining) ? srrs_pkg::LEN_W'(room)
                                                         : r_remaining;
        seg_done = r_rem_next == '0;
        at_limit = r_cnt == CNT_LAST;
        seg_last = seg_done || at_limit;
        ram_waddr = AW'(i_job.index);
        ram_raddr = r_qd[AW-1:0];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srrs_pkg::BK_IDLE: begin
                if (head_valid && (i_job.kind == srrs_pkg::JOB_SPLIT)) begin
                    n_state = srrs_pkg::BK_DIV;
                end
            end
            srrs_pkg::BK_DIV: begin
                if (r_div_cnt == DIV_LAST) begin
                    n_state = srrs_pkg::BK_CHECK;
                end
            end
            srrs_pkg::BK_CHECK: begin
                n_state = beyond ? srrs_pkg::BK_BEYOND : srrs_pkg::BK_MUL;
            end
            srrs_pkg::BK_MUL: begin
                n_state = srrs_pkg::BK_EMIT;
            end
            srrs_pkg::BK_EMIT: begin
                if (out_free) begin
                    n_state = seg_last ? srrs_pkg::BK_IDLE : srrs_pkg::BK_CHECK;
                end
            end
            srrs_pkg::BK_BEYOND: begin
                if (out_free) begin
                    n_state = srrs_pkg::BK_IDLE;
                end
            end
            default: n_state = srrs_pkg::BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_job_pop = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        out_load  = 1'b0;
        out_data  = '0;
        out_data.last = 1'b1;
        unique case (r_state)
            srrs_pkg::BK_IDLE: begin
                if (head_valid) begin
                    if (head_single) begin
                        o_job_pop = out_free;
                        out_load  = out_free;
                        if (i_job.kind == srrs_pkg::JOB_PASS) begin
                            out_data.seg_offset = srrs_pkg::OFF_W'(i_job.pos);
                            out_data.seg_length = i_job.len;
                        end
                    end else begin
                        o_job_pop = 1'b1;
                        ram_we    = i_job.kind == srrs_pkg::JOB_LOAD;
                    end
                end
            end
            srrs_pkg::BK_CHECK: begin
                ram_re = !beyond;
            end
            srrs_pkg::BK_EMIT: begin
                out_load            = out_free;
                out_data.seg_offset = srrs_pkg::OFF_W'(r_base_within)
                                      + srrs_pkg::OFF_W'(r_prod);
                out_data.seg_length = r_len;
                out_data.last       = seg_last;
                out_data.status     = (!seg_done && at_limit) ? srrs_pkg::STATUS_CUT
                                                              : srrs_pkg::STATUS_OK;
            end
            srrs_pkg::BK_BEYOND: begin
                out_load        = out_free;
                out_data.status = srrs_pkg::STATUS_BEYOND;
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srrs_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            r_div_cnt   <= '0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == srrs_pkg::BK_IDLE) begin
                r_div_cnt <= '0;
                r_cnt     <= '0;
            end else if (r_state == srrs_pkg::BK_DIV) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end else if ((r_state == srrs_pkg::BK_EMIT) && out_free && !seg_last) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
        unique case (r_state)
            srrs_pkg::BK_IDLE: begin
                r_qd        <= i_job.pos;
                r_rem       <= '0;
                r_remaining <= i_job.len;
                r_ss        <= ss_eff;
            end
            srrs_pkg::BK_DIV: begin
                r_qd  <= {r_qd[srrs_pkg::POS_W-2:0], div_ge};
                r_rem <= rem_new;
            end
            srrs_pkg::BK_CHECK: begin
                r_len         <= seg_len;
                r_rem_next    <= r_remaining - seg_len;
                r_base_within <= srrs_pkg::BW_W'(i_cfg.base) + srrs_pkg::BW_W'(r_rem);
            end
            srrs_pkg::BK_MUL: begin
                r_prod <= srrs_pkg::PROD_W'(ram_rdata) * srrs_pkg::PROD_W'(r_ss);
            end
            srrs_pkg::BK_EMIT: begin
                // next sector starts at its first byte
                if (out_free && !seg_last) begin
                    r_qd        <= r_qd + 1'b1;
                    r_rem       <= '0;
                    r_remaining <= r_rem_next;
                end
            end
            default: begin
                r_rem <= r_rem;
            end
        endcase
    end

    assign o_seg   = r_out;
    assign o_empty = !r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/core/sector_remap_read_splitter_core.sv =====
// top level of the sector remap read splitter: config registers, front end, job queue, back end
// a load is written into the remap table by the back end; an empty or pass-through read
// passes through the job queue and is then held in the output register; a split read runs a
// serial divide by the sector size, then each segment steps through table read, multiply by
// sector size, and offset add and output, waiting there until the output register is free
// synchronous active-low reset clears control state and loads the register defaults;
// the remap table is not cleared and holds undefined data until entries are loaded
`default_nettype none

`include "sector_remap_read_splitter_core_macros.svh"

module sector_remap_read_splitter_core #(
    parameter int TABLE_DEPTH  = srrs_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_SEGMENTS = srrs_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           push,
    output logic                                full,
    input  wire srrs_pkg::t_in_item             i_item,
    output logic                                empty,
    input  wire logic                           pop,
    output srrs_pkg::t_out_item                 o_seg,
    input  wire logic                           i_cfg_we,
    input  wire logic [srrs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [srrs_pkg::CFG_W-1:0]     i_cfg_wdata
);

    srrs_pkg::t_cfg  r_cfg;
    logic            job_push;
    logic            job_full;
    logic            job_pop;
    logic            job_empty;
    srrs_pkg::t_job  job_in;
    srrs_pkg::t_job  job_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode        <= 1'b0;
            r_cfg.sec_bytes   <= srrs_pkg::RST_SECTOR;
            r_cfg.image_size  <= '0;
            r_cfg.base        <= '0;
        end else if (i_cfg_we) begin
            unique case (srrs_pkg::t_cfg_idx'(i_cfg_idx))
                srrs_pkg::CFG_MODE:       r_cfg.mode       <= i_cfg_wdata[0];
                srrs_pkg::CFG_SEC_BYTES:  r_cfg.sec_bytes  <= i_cfg_wdata[srrs_pkg::SS_W-1:0];
                srrs_pkg::CFG_IMAGE_SIZE: r_cfg.image_size <= i_cfg_wdata[srrs_pkg::IMG_W-1:0];
                srrs_pkg::CFG_BASE:       r_cfg.base       <= i_cfg_wdata[srrs_pkg::BASE_W-1:0];
                default:                  r_cfg            <= r_cfg;
            endcase
        end
    end

    srrs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_item     (i_item),
        .i_push     (push),
        .o_full     (full),
        .i_cfg      (r_cfg),
        .i_job_full (job_full),
        .o_job_push (job_push),
        .o_job      (job_in)
    );

    srrs_job_fifo u_jobs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_job   (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_head  (job_head),
        .o_empty (job_empty)
    );

    srrs_back #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_SEGMENTS (MAX_SEGMENTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_empty (job_empty),
        .i_job       (job_head),
        .o_job_pop   (job_pop),
        .o_seg       (o_seg),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    // a queued job is visible to the back end on the next cycle
    `SRRS_ASSERT_NEXT(a_job_push_fills, i_clk, i_rst_n, job_push, !job_empty, "job lost after push")
    `SRRS_ASSERT_NOW(a_no_pop_when_empty, i_clk, i_rst_n, job_empty, !job_pop, "pop from empty queue")
    // a cut or beyond-table flag always closes the read
    `SRRS_ASSERT_NOW(a_flag_ends_read, i_clk, i_rst_n, !empty && (o_seg.status != srrs_pkg::STATUS_OK), o_seg.last, "flagged item not last")

endmodule

`default_nettype wire

// ===== verif/sector_remap_read_splitter_checker.sv =====
// checker for the sector remap read splitter: predicts the segments of every read and compares them
`timescale 1ns / 1ps

module sector_remap_read_splitter_checker
    import srrs_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int MAX_SEGMENTS = DEF_MAX_SEGMENTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic                 i_full,
    input  t_in_item             i_item,
    input  logic                 i_empty,
    input  logic                 i_pop,
    input  t_out_item            i_seg,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    output int                   o_mismatches,
    output int                   o_segs_owed
);

    logic              split_mode   = 1'b0;
    logic [SS_W-1:0]   sector_bytes = RST_SECTOR;
    logic [IMG_W-1:0]  image_bytes  = '0;
    logic [BASE_W-1:0] array_base   = '0;
    logic [VAL_W-1:0]  sector_map [TABLE_DEPTH];
    t_out_item         segs_due [$];
    int                mismatches   = 0;

    function automatic void owe_segment(logic [63:0] off, logic [63:0] len, logic fin,
                                        logic [1:0] st);
        t_out_item seg;
        seg.seg_offset = off[OFF_W-1:0];
        seg.seg_length = len[LEN_W-1:0];
        seg.last       = fin;
        seg.status     = st;
        segs_due.push_back(seg);
    endfunction

    // clip to the image, then walk the sectors one segment at a time
    function automatic void plan_read(logic [POS_W-1:0] start, logic [LEN_W-1:0] want);
        logic [63:0] pos;
        logic [63:0] left;
        logic [63:0] ss;
        logic [63:0] sec;
        logic [63:0] in_sec;
        logic [63:0] len;
        logic [63:0] phys_off;
        int          k;
        pos  = 64'(start);
        left = 64'(want);
        if (pos >= 64'(image_bytes)) begin
            owe_segment(64'd0, 64'd0, 1'b1, STATUS_OK);
            return;
        end
        if (64'(image_bytes) - pos < left) left = 64'(image_bytes) - pos;
        if (left == 0) begin
            owe_segment(64'd0, 64'd0, 1'b1, STATUS_OK);
            return;
        end
        if (!split_mode) begin
            owe_segment(pos, left, 1'b1, STATUS_OK);
            return;
        end
        ss = (sector_bytes < MIN_SECTOR) ? 64'(MIN_SECTOR) : 64'(sector_bytes);
        for (k = 0; k < MAX_SEGMENTS; k++) begin
            sec    = pos / ss;
            in_sec = pos % ss;
            len    = (ss - in_sec < left) ? ss - in_sec : left;
            if (sec >= 64'(TABLE_DEPTH)) begin
                owe_segment(64'd0, 64'd0, 1'b1, STATUS_BEYOND);
                return;
            end
            phys_off = 64'(array_base) + 64'(sector_map[sec]) * ss + in_sec;
            left     = left - len;
            if (left == 0) begin
                owe_segment(phys_off, len, 1'b1, STATUS_OK);
                return;
            end
            if (k == MAX_SEGMENTS - 1) begin
                owe_segment(phys_off, len, 1'b1, STATUS_CUT);
                return;
            end
            owe_segment(phys_off, len, 1'b0, STATUS_OK);
            pos = pos + len;
        end
    endfunction

    function automatic void check_segment(t_out_item got);
        t_out_item want;
        if (segs_due.size() == 0) begin
            $error("segment with nothing outstanding: offset %0h length %0h",
                   got.seg_offset, got.seg_length);
            mismatches++;
            return;
        end
        want = segs_due.pop_front();
        if (got.seg_offset !== want.seg_offset) begin
            $error("seg_offset: expected %0h, got %0h", want.seg_offset, got.seg_offset);
            mismatches++;
        end
        if (got.seg_length !== want.seg_length) begin
            $error("seg_length: expected %0h, got %0h", want.seg_length, got.seg_length);
            mismatches++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, got.last);
            mismatches++;
        end
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            split_mode   = 1'b0;
            sector_bytes = RST_SECTOR;
            image_bytes  = '0;
            array_base   = '0;
            segs_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_MODE:       split_mode   = i_cfg_wdata[0];
                    CFG_SEC_BYTES:  sector_bytes = i_cfg_wdata[SS_W-1:0];
                    CFG_IMAGE_SIZE: image_bytes  = i_cfg_wdata[IMG_W-1:0];
                    CFG_BASE:       array_base   = i_cfg_wdata[BASE_W-1:0];
                    default: ;
                endcase
            end
            // results trail their read by cycles, so check before taking the new item
            if (i_pop && !i_empty) check_segment(i_seg);
            if (i_push && !i_full) begin
                if (i_item.cmd == CMD_LOAD) begin
                    if (i_item.entry_index < TABLE_DEPTH)
                        sector_map[i_item.entry_index] = i_item.entry_value;
                end else begin
                    plan_read(i_item.read_offset, i_item.read_length);
                end
            end
        end
        o_mismatches <= mismatches;
        o_segs_owed  <= segs_due.size();
    end

endmodule

// ===== verif/tb_sector_remap_read_splitter_core.sv =====
// testbench top for the sector remap read splitter: table loads, reads, settings and verdict
`timescale 1ns / 1ps

module tb_sector_remap_read_splitter_core;
    import srrs_pkg::*;

    localparam int               IDLE_LIMIT    = 2000;
    localparam int               SETTLE_CYCLES = 50;
    localparam int               PHASES        = 7;
    localparam int               PHASE_ITEMS   = 48;
    localparam logic [IMG_W-1:0] IMAGE_MAX     = 41'h100_0000_0000;
    localparam logic [63:0]      BIG_SECTOR    = 64'h0FFF_FFFF;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 push        = 1'b0;
    logic                 pop         = 1'b0;
    logic                 full;
    logic                 empty;
    t_in_item             i_item      = '0;
    t_out_item            o_seg;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_MODE;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;
    int                   seg_mismatches;
    int                   segs_owed;

    // stimulus-side view of the settings and of the table entries loaded so far
    logic                 now_split  = 1'b0;
    logic [SS_W-1:0]      now_sector = RST_SECTOR;
    logic [IMG_W-1:0]     now_image  = '0;
    bit                   loaded [DEF_TABLE_DEPTH];
    bit                   calm       = 1'b0;

    int idle_cycles = 0;
    int n_loads     = 0;
    int n_reads     = 0;
    int n_settings  = 0;
    int n_segs      = 0;
    int n_cut       = 0;
    int n_beyond    = 0;
    int n_void      = 0;

    sector_remap_read_splitter_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_seg       (o_seg),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    sector_remap_read_splitter_checker seg_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_item       (i_item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_seg        (o_seg),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_mismatches (seg_mismatches),
        .o_segs_owed  (segs_owed)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || i_cfg_we) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (pop && !empty) begin
            n_segs <= n_segs + 1;
            if (o_seg.status == STATUS_CUT) n_cut <= n_cut + 1;
            if (o_seg.status == STATUS_BEYOND) n_beyond <= n_beyond + 1;
            if (o_seg.status == STATUS_OK && o_seg.seg_length == '0) n_void <= n_void + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls, mostly short, held off entirely in calm phases
    initial begin : result_side
        int run_len;
        int stall;
        @(posedge i_clk);
        forever begin
            if (calm) begin
                pop <= 1'b1;
                @(posedge i_clk);
            end else begin
                pop <= 1'b1;
                run_len = $urandom_range(1, 12);
                repeat (run_len) @(posedge i_clk);
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(0, 3);
                if (stall != 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] eff_sector();
        return (now_sector < MIN_SECTOR) ? 64'(MIN_SECTOR) : 64'(now_sector);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_in_item noise_item();
        logic [127:0] raw;
        t_in_item     it;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it  = raw[$bits(t_in_item)-1:0];
        return it;
    endfunction

    // push stays high when the next item follows straight on
    task automatic send(input t_in_item it);
        int gap;
        i_item <= it;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        if (it.cmd == CMD_LOAD) n_loads++;
        else n_reads++;
        gap = idle_gap();
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        do @(posedge i_clk); while (segs_owed != 0);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        i_cfg_we    <= 1'b1;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_MODE:       now_split  = val[0];
            CFG_SEC_BYTES:  now_sector = val[SS_W-1:0];
            CFG_IMAGE_SIZE: now_image  = val[IMG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic mode, input logic [SS_W-1:0] ss,
                                 input logic [IMG_W-1:0] img, input logic [BASE_W-1:0] base);
        settle();
        set_reg(CFG_MODE, CFG_W'(mode));
        set_reg(CFG_SEC_BYTES, CFG_W'(ss));
        set_reg(CFG_IMAGE_SIZE, CFG_W'(img));
        set_reg(CFG_BASE, CFG_W'(base));
        n_settings++;
    endtask

    task automatic load_entry(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] val);
        t_in_item it;
        it             = noise_item();
        it.cmd         = CMD_LOAD;
        it.entry_index = idx;
        it.entry_value = val;
        loaded[idx]    = 1'b1;
        send(it);
    endtask

    // loads every sector the read will look up first, so no unwritten entry is read
    task automatic request_read(input logic [POS_W-1:0] pos, input logic [LEN_W-1:0] len);
        logic [63:0] p;
        logic [63:0] left;
        logic [63:0] ss;
        logic [63:0] sec;
        logic [63:0] step;
        int          k;
        t_in_item    it;
        if (now_split && 64'(pos) < 64'(now_image)) begin
            p    = 64'(pos);
            left = 64'(len);
            if (64'(now_image) - p < left) left = 64'(now_image) - p;
            ss = eff_sector();
            for (k = 0; k < DEF_MAX_SEGMENTS && left != 0; k++) begin
                sec = p / ss;
                if (sec >= 64'(DEF_TABLE_DEPTH)) break;
                if (!loaded[sec]) load_entry(sec[IDX_W-1:0], VAL_W'($urandom));
                step = ss - p % ss;
                if (step > left) step = left;
                left = left - step;
                p    = p + step;
            end
        end
        it             = noise_item();
        it.cmd         = CMD_READ;
        it.read_offset = pos;
        it.read_length = len;
        send(it);
    endtask

    task automatic random_read();
        logic [63:0] ss;
        logic [63:0] pos;
        logic [63:0] len;
        logic [63:0] sec;
        int          r;
        ss = eff_sector();
        r  = $urandom_range(0, 99);
        if (r < 65) begin
            // mostly sectors that are already in use, a few anywhere in the table
            sec = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 47);
            pos = sec * ss + $urandom_range(0, 32'(ss - 1));
            if (pos >= 64'(now_image) && now_image != 0 && $urandom_range(0, 3) != 0)
                pos = rand64() % 64'(now_image);
            case ($urandom_range(0, 9))
                0:       len = 0;
                1:       len = ss - pos % ss;
                2:       len = 64 * ss;
                default: len = $urandom_range(1, 32'(3 * ss));
            endcase
        end else if (r < 80) begin
            // close to the end of the image
            pos = (now_image > 600) ? 64'(now_image) - $urandom_range(0, 600)
                                    : $urandom_range(0, 600);
            len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 2000) : $urandom;
        end else if (r < 90) begin
            pos = rand64();
            len = $urandom;
        end else begin
            pos = (now_image != 0) ? rand64() % 64'(now_image) : rand64();
            len = $urandom;
        end
        request_read(pos[POS_W-1:0], len[LEN_W-1:0]);
    endtask

    task automatic random_setting();
        logic [SS_W-1:0]   ss;
        logic [63:0]       ss_eff;
        logic [63:0]       img;
        logic [BASE_W-1:0] base;
        logic              mode;
        mode = ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 9))
            0:       ss = '0;
            1:       ss = $urandom_range(1, 255);
            2:       ss = MIN_SECTOR;
            3:       ss = MIN_SECTOR + 1;
            4, 5:    ss = $urandom_range(256, 4096);
            6:       ss = RST_SECTOR;
            7:       ss = SS_W'($urandom);
            8:       ss = '1;
            default: ss = 28'd512;
        endcase
        ss_eff = (ss < MIN_SECTOR) ? 64'(MIN_SECTOR) : 64'(ss);
        case ($urandom_range(0, 7))
            0:       img = 0;
            1:       img = $urandom_range(1, 5000);
            2, 3:    img = ss_eff * $urandom_range(1, 70000);
            4:       img = 64'(IMAGE_MAX);
            5, 6:    img = rand64() & 64'(IMAGE_MAX);
            default: img = 64'(IMAGE_MAX) - $urandom_range(0, 1000);
        endcase
        if (img > 64'(IMAGE_MAX)) img = 64'(IMAGE_MAX);
        case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            default: base = BASE_W'(rand64());
        endcase
        apply_setting(mode, ss, img[IMG_W-1:0], base);
    endtask

    initial begin : stimulus
        int  phase;
        int  phase_start;
        bit  held;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: image size zero, so nothing is readable
        request_read(40'd0, 32'd100);
        request_read('1, '1);

        // pass-through over the largest image
        apply_setting(1'b0, RST_SECTOR, IMAGE_MAX, 40'h12_3456_789A);
        request_read(40'd0, 32'd0);
        request_read('1, '1);
        request_read(40'd0, '1);
        load_entry(16'd0, '1);
        load_entry('1, 16'd0);

        // split mode, sector size below the minimum, top base
        apply_setting(1'b1, '0, IMAGE_MAX, '1);
        request_read(40'd300, 32'd600);
        request_read(40'd0, '1);
        request_read(40'd0, 32'(64 * 256));
        request_read(40'(65535 * 256 + 10), 32'd1000);
        request_read(40'(65536 * 256), 32'd5);

        // largest sector size, image ends inside the fourth sector
        apply_setting(1'b1, '1, IMG_W'(3 * BIG_SECTOR + 100), '0);
        request_read(40'(BIG_SECTOR - 5), 32'd20);
        request_read(40'(3 * BIG_SECTOR), 32'd500);
        request_read(40'(3 * BIG_SECTOR + 100), 32'd1);
        request_read(40'(2 * BIG_SECTOR), 32'd0);

        for (phase = 0; phase < PHASES; phase++) begin
            random_setting();
            calm        = (phase == 3);
            held        = 1'b0;
            phase_start = n_loads + n_reads;
            while (n_loads + n_reads - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 30) begin
                    load_entry(($urandom_range(0, 1) == 0) ? IDX_W'($urandom_range(0, 63))
                                                           : IDX_W'($urandom),
                               VAL_W'($urandom));
                end else begin
                    random_read();
                end
                // sender holds off until every segment so far has come back
                if (phase % 2 == 0 && !held && n_loads + n_reads - phase_start >= 25) begin
                    drain();
                    held = 1'b1;
                end
            end
        end
        calm = 1'b0;
        settle();

        $display("covered %0d table loads and %0d reads over %0d register settings",
                 n_loads, n_reads, n_settings);
        $display("%0d segments back: %0d cut at the limit, %0d beyond the table, %0d empty",
                 n_segs, n_cut, n_beyond, n_void);
        if (seg_mismatches == 0 && segs_owed == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
